>>> hdl/es2cdt_pkg.sv
// Shared widths, constants and reciprocal multipliers for the epoch-to-civil converter.
// No dependencies; imported by es2cdt_date, es2cdt_time and the top level.
package es2cdt_pkg;

    localparam int EPOCH_W = 38;
    localparam int DATE_W  = 27;
    localparam int TIME_W  = 18;
    localparam int DAYS_W  = 22;
    localparam int SOD_W   = 17;

    localparam logic [EPOCH_W-1:0] MAX_EPOCH = 38'd253402300799;

    // Stage counts: front split, then the date and time paths in parallel.
    localparam int SPLIT_STAGES = 3;
    localparam int PATH_STAGES  = 8;
    localparam int LATENCY      = SPLIT_STAGES + PATH_STAGES;

    localparam logic [21:0] SHIFT_TO_MARCH_ZERO = 22'd719468;
    localparam logic [21:0] DAYS_PER_ERA        = 22'd146097;

    // Exact floor division by multiply-high: m = ceil(2^(N+l) / d), l = ceil(log2 d),
    // valid for every N-bit dividend.
    // 31-bit seconds/128 divided by 675 (86400 = 128 * 675)
    localparam logic [31:0] RECIP_DAY   = 32'(((64'd1 << 41) + 64'd674) / 64'd675);
    // 22-bit shifted day count divided by days per 400 years
    localparam logic [22:0] RECIP_ERA   = 23'(((64'd1 << 40) + 64'd146096) / 64'd146097);
    // 18-bit day of era divided by 1460
    localparam logic [18:0] RECIP_1460  = 19'(((64'd1 << 29) + 64'd1459) / 64'd1460);
    // 18-bit value divided by 365
    localparam logic [18:0] RECIP_YEAR  = 19'(((64'd1 << 27) + 64'd364) / 64'd365);
    // 11-bit value divided by 153
    localparam logic [11:0] RECIP_MONTH = 12'(((64'd1 << 19) + 64'd152) / 64'd153);
    // 17-bit seconds of day divided by 60
    localparam logic [17:0] RECIP_MIN   = 18'(((64'd1 << 23) + 64'd59) / 64'd60);
    // 11-bit minutes of day divided by 60
    localparam logic [11:0] RECIP_HOUR  = 12'(((64'd1 << 17) + 64'd59) / 64'd60);

    // Day of the March-based year on which month index mp starts: (153*mp + 2) / 5
    function automatic logic [8:0] month_start(input logic [3:0] mp);
        logic [8:0] r;
        case (mp)
            4'd0:    r = 9'd0;
            4'd1:    r = 9'd31;
            4'd2:    r = 9'd61;
            4'd3:    r = 9'd92;
            4'd4:    r = 9'd122;
            4'd5:    r = 9'd153;
            4'd6:    r = 9'd184;
            4'd7:    r = 9'd214;
            4'd8:    r = 9'd245;
            4'd9:    r = 9'd275;
            4'd10:   r = 9'd306;
            4'd11:   r = 9'd337;
            default: r = 9'd0;
        endcase
        return r;
    endfunction

endpackage

>>> hdl/es2cdt_date.sv
// Day count since 1970-01-01 to packed YYYYMMDD, eight register stages.
// Depends on es2cdt_pkg.
module es2cdt_date (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           vld,
    input  logic [es2cdt_pkg::DAYS_W-1:0]  days,
    output logic                           date_vld,
    output logic [es2cdt_pkg::DATE_W-1:0]  date_code
);
    import es2cdt_pkg::*;

    logic [PATH_STAGES-1:0] vld_reg;

    // stage 1: shift to a March-based calendar, era estimate
    logic [21:0] z_next, z_reg;
    logic [44:0] eprod_next, eprod_reg;
    // stage 2: era and day of era
    logic [4:0]  era_next, era2_reg, era3_reg, era4_reg, era5_reg;
    logic [17:0] doe_next, doe2_reg, doe3_reg, doe4_reg;
    // stage 3: century and quadrennial corrections
    logic [36:0] qprod_next, qprod_reg;
    logic [2:0]  cent_next, cent_reg;
    logic        last_next, last_reg;
    // stage 4: year of era estimate
    logic [17:0] n_next;
    logic [36:0] yprod_next, yprod_reg;
    // stage 5: year of era, day of year
    logic [8:0]  yoe_next, yoe_reg;
    logic [1:0]  c100;
    logic [17:0] ydays;
    logic [8:0]  doy_next, doy5_reg, doy6_reg;
    // stage 6: month index estimate and base year
    logic [10:0] mv;
    logic [22:0] mprod_next, mprod_reg;
    logic [13:0] base_next, base_reg;
    // stage 7: day, month, year
    logic [3:0]  mp;
    logic [4:0]  day_next, day_reg;
    logic [3:0]  month_next, month_reg;
    logic [13:0] year_next, year_reg;
    // stage 8: packed code
    logic [DATE_W-1:0] code_next, code_reg;

    always_comb
    begin
        z_next     = days + SHIFT_TO_MARCH_ZERO;
        eprod_next = 45'(z_next) * 45'(RECIP_ERA);

        era_next   = eprod_reg[44:40];
        doe_next   = 18'(z_reg - 22'(era_next) * DAYS_PER_ERA);

        qprod_next = 37'(doe2_reg) * 37'(RECIP_1460);
        cent_next  = 3'(doe2_reg >= 18'd36524) + 3'(doe2_reg >= 18'd73048)
                   + 3'(doe2_reg >= 18'd109572) + 3'(doe2_reg >= 18'd146096);
        last_next  = (doe2_reg == 18'd146096);

        n_next     = doe3_reg - 18'(qprod_reg[36:29]) + 18'(cent_reg) - 18'(last_reg);
        yprod_next = 37'(n_next) * 37'(RECIP_YEAR);

        yoe_next   = yprod_reg[35:27];
        c100       = 2'(yoe_next >= 9'd100) + 2'(yoe_next >= 9'd200)
                   + 2'(yoe_next >= 9'd300);
        ydays      = 18'(yoe_next) * 18'd365 + 18'(yoe_next[8:2]) - 18'(c100);
        doy_next   = 9'(doe4_reg - ydays);

        mv         = 11'(doy5_reg) * 11'd5 + 11'd2;
        mprod_next = 23'(mv) * 23'(RECIP_MONTH);
        base_next  = 14'(yoe_reg) + 14'(era5_reg) * 14'd400;

        mp         = mprod_reg[22:19];
        day_next   = 5'(doy6_reg - month_start(mp) + 9'd1);
        month_next = (mp < 4'd10) ? (mp + 4'd3) : (mp - 4'd9);
        year_next  = base_reg + 14'(month_next <= 4'd2);

        code_next  = 27'(year_reg) * 27'd10000 + 27'(month_reg) * 27'd100
                   + 27'(day_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[PATH_STAGES-2:0], vld};
        end
    end

    always_ff @(posedge clk)
    begin
        z_reg     <= z_next;
        eprod_reg <= eprod_next;
        era2_reg  <= era_next;
        doe2_reg  <= doe_next;
        qprod_reg <= qprod_next;
        cent_reg  <= cent_next;
        last_reg  <= last_next;
        doe3_reg  <= doe2_reg;
        era3_reg  <= era2_reg;
        yprod_reg <= yprod_next;
        doe4_reg  <= doe3_reg;
        era4_reg  <= era3_reg;
        yoe_reg   <= yoe_next;
        doy5_reg  <= doy_next;
        era5_reg  <= era4_reg;
        mprod_reg <= mprod_next;
        doy6_reg  <= doy5_reg;
        base_reg  <= base_next;
        day_reg   <= day_next;
        month_reg <= month_next;
        year_reg  <= year_next;
        code_reg  <= code_next;
    end

    assign date_vld  = vld_reg[PATH_STAGES-1];
    assign date_code = code_reg;

endmodule

>>> hdl/es2cdt_time.sv
// Seconds of day to packed HHMMSS, eight register stages to match the date path.
// Depends on es2cdt_pkg.
module es2cdt_time (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           vld,
    input  logic [es2cdt_pkg::SOD_W-1:0]   sod,
    output logic                           time_vld,
    output logic [es2cdt_pkg::TIME_W-1:0]  time_code
);
    import es2cdt_pkg::*;

    localparam int DLY = PATH_STAGES - 4;

    logic [PATH_STAGES-1:0] vld_reg;

    logic [34:0]       mprod_next, mprod_reg;
    logic [SOD_W-1:0]  sod_reg;
    logic [10:0]       mtot_next, mtot2_reg, mtot3_reg;
    logic [5:0]        ss_next, ss2_reg, ss3_reg, ss4_reg;
    logic [22:0]       hprod_next, hprod_reg;
    logic [4:0]        hh_next, hh_reg;
    logic [5:0]        mm_next, mm_reg;
    logic [TIME_W-1:0] code_next;
    // trailing delay to line up with the date word
    logic [TIME_W-1:0] code_reg [DLY];

    always_comb
    begin
        mprod_next = 35'(sod) * 35'(RECIP_MIN);
        mtot_next  = mprod_reg[33:23];
        ss_next    = 6'(sod_reg - 17'(mtot_next) * 17'd60);
        hprod_next = 23'(mtot2_reg) * 23'(RECIP_HOUR);
        hh_next    = hprod_reg[21:17];
        mm_next    = 6'(mtot3_reg - 11'(hh_next) * 11'd60);
        code_next  = 18'(hh_reg) * 18'd10000 + 18'(mm_reg) * 18'd100 + 18'(ss4_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[PATH_STAGES-2:0], vld};
        end
    end

    always_ff @(posedge clk)
    begin
        mprod_reg <= mprod_next;
        sod_reg   <= sod;
        mtot2_reg <= mtot_next;
        ss2_reg   <= ss_next;
        hprod_reg <= hprod_next;
        mtot3_reg <= mtot2_reg;
        ss3_reg   <= ss2_reg;
        hh_reg    <= hh_next;
        mm_reg    <= mm_next;
        ss4_reg   <= ss3_reg;
        code_reg[0] <= code_next;
        for (int i = 1; i < DLY; i++)
        begin
            code_reg[i] <= code_reg[i-1];
        end
    end

    assign time_vld  = vld_reg[PATH_STAGES-1];
    assign time_code = code_reg[DLY-1];

endmodule

>>> hdl/epoch_seconds_to_civil_date_time.sv
// Top level: epoch seconds to packed Gregorian date and time of day.
// Depends on es2cdt_pkg, es2cdt_date and es2cdt_time.

// Fully pipelined converter: one word may be started in every clock cycle and
// busy never rises. Each word comes out with done high for a single cycle; the
// pipeline depth is set by the date path, whose chain of reciprocal multiplies
// turns the day count into year, month and day. Results leave in the order
// words were started and cannot be held off. Times past the last second of
// year 9999 give 99991231 / 235959.
module epoch_seconds_to_civil_date_time (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [es2cdt_pkg::EPOCH_W-1:0] epoch_seconds,
    output logic                           done,
    output logic [es2cdt_pkg::DATE_W-1:0]  date_code,
    output logic [es2cdt_pkg::TIME_W-1:0]  time_code
);
    import es2cdt_pkg::*;

    logic [SPLIT_STAGES-1:0] vld_reg;

    logic [EPOCH_W-1:0] t_next, t_reg;
    logic [30:0]        x_next, x_reg;
    logic [6:0]         lo_reg;
    logic [62:0]        prod_next, prod_reg;
    logic [DAYS_W-1:0]  days_next, days_reg;
    logic [31:0]        rem_full;
    logic [SOD_W-1:0]   sod_next, sod_reg;
    logic               date_vld;
    logic               time_vld;

    // 86400 = 128 * 675: the low seven bits ride along, the rest divides by 675
    always_comb
    begin
        t_next    = (epoch_seconds > MAX_EPOCH) ? MAX_EPOCH : epoch_seconds;
        x_next    = t_reg[EPOCH_W-1:7];
        prod_next = 63'(x_next) * 63'(RECIP_DAY);
        days_next = prod_reg[62:41];
        rem_full  = 32'(x_reg) - 32'(days_next) * 32'd675;
        sod_next  = {rem_full[9:0], lo_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[SPLIT_STAGES-2:0], start};
        end
    end

    always_ff @(posedge clk)
    begin
        t_reg    <= t_next;
        x_reg    <= x_next;
        lo_reg   <= t_reg[6:0];
        prod_reg <= prod_next;
        days_reg <= days_next;
        sod_reg  <= sod_next;
    end

    es2cdt_date u_date (
        .clk       (clk),
        .rst_n     (rst_n),
        .vld       (vld_reg[SPLIT_STAGES-1]),
        .days      (days_reg),
        .date_vld  (date_vld),
        .date_code (date_code)
    );

    es2cdt_time u_time (
        .clk       (clk),
        .rst_n     (rst_n),
        .vld       (vld_reg[SPLIT_STAGES-1]),
        .sod       (sod_reg),
        .time_vld  (time_vld),
        .time_code (time_code)
    );

    assign busy = 1'b0;
    assign done = date_vld;

    // the two paths must stay in lock step
    a_paths_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        date_vld == time_vld)
        else $error("date and time paths out of step");

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##(LATENCY) done)
        else $error("word started but no result after pipeline latency");

    a_date_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (date_code >= 27'd19700101 && date_code <= 27'd99991231))
        else $error("date code out of range");

    a_time_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (time_code <= 18'd235959))
        else $error("time code out of range");

endmodule
